>>> src/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, constants and character tables of the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	localparam int CHUNK_SIZE_BITS = 32;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] PREFIX_LEN  = 3'd5;
	localparam logic [4:0] PATTERN_LEN = 5'd26;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_LOW_T = 8'h74;

	localparam logic [2:0] FL_DIGIT = 3'b001;
	localparam logic [2:0] FL_TRAIL = 3'b010;
	localparam logic [2:0] FL_EXT   = 3'b100;

	localparam logic [1:0] LE_NONE  = 2'd0;
	localparam logic [1:0] LE_CR    = 2'd1;
	localparam logic [1:0] LE_CRLF  = 2'd2;
	localparam logic [1:0] LE_CRLFCR = 2'd3;

	typedef logic [CHUNK_SIZE_BITS-1:0] chunk_size_t;

	typedef enum logic [3:0] {
		PH_PREFIX  = 4'd0,
		PH_HEADER  = 4'd1,
		PH_PLAIN   = 4'd2,
		PH_SIZE    = 4'd3,
		PH_SIZE_LF = 4'd4,
		PH_DATA    = 4'd5,
		PH_DATA_CR = 4'd6,
		PH_DATA_LF = 4'd7
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic [7:0] lower;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_cr;
		logic       is_lf;
		logic       is_blank;
		logic       is_semi;
		logic       last;
	} byte_cls_t;

	typedef struct packed {
		logic      push;
		byte_cls_t entry;
	} queue_wr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h48;
			3'd1:    c = 8'h54;
			3'd2:    c = 8'h54;
			3'd3:    c = 8'h50;
			3'd4:    c = 8'h2f;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] pattern_char(input logic [4:0] idx);
		logic [7:0] c;
		unique case (idx)
			5'd0:    c = "t";
			5'd1:    c = "r";
			5'd2:    c = "a";
			5'd3:    c = "n";
			5'd4:    c = "s";
			5'd5:    c = "f";
			5'd6:    c = "e";
			5'd7:    c = "r";
			5'd8:    c = "-";
			5'd9:    c = "e";
			5'd10:   c = "n";
			5'd11:   c = "c";
			5'd12:   c = "o";
			5'd13:   c = "d";
			5'd14:   c = "i";
			5'd15:   c = "n";
			5'd16:   c = "g";
			5'd17:   c = ":";
			5'd18:   c = " ";
			5'd19:   c = "c";
			5'd20:   c = "h";
			5'd21:   c = "u";
			5'd22:   c = "n";
			5'd23:   c = "k";
			5'd24:   c = "e";
			5'd25:   c = "d";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> src/hcbd_in_if.sv
// ----------------------------------------------------------------------------
// hcbd_in_if
// Raw response byte channel: one byte and its end-of-response flag per word.
// ----------------------------------------------------------------------------
interface hcbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> src/hcbd_out_if.sv
// ----------------------------------------------------------------------------
// hcbd_out_if
// Decoded result channel: payload byte and outcome flags per word.
// ----------------------------------------------------------------------------
interface hcbd_out_if;
	logic       valid;
	logic       ready;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic       finished;
	logic       success;

	modport source (output valid, output payload_valid, output payload_byte,
		output finished, output success, input ready);
	modport sink   (input valid, input payload_valid, input payload_byte,
		input finished, input success, output ready);
endinterface

>>> src/hcbd_front.sv
// ----------------------------------------------------------------------------
// hcbd_front
// Accepts raw bytes and classifies them for the decoder back end.
// ----------------------------------------------------------------------------
module hcbd_front (
	hcbd_in_if.sink                raw,
	input  hcbd_pkg::queue_status_t qstat,
	output hcbd_pkg::queue_wr_t     qwr
);

	logic [7:0] d;

	assign d = raw.data_byte;
	assign raw.ready = !qstat.full;

	always_comb begin
		qwr.push           = raw.valid && !qstat.full;
		qwr.entry.data     = d;
		qwr.entry.lower    = (d >= 8'h41 && d <= 8'h5a) ? (d + 8'd32) : d;
		qwr.entry.is_hex   = 1'b0;
		qwr.entry.hex_val  = 4'd0;
		if (d >= 8'h30 && d <= 8'h39) begin
			qwr.entry.is_hex  = 1'b1;
			qwr.entry.hex_val = d[3:0];
		end else if ((d >= 8'h61 && d <= 8'h66) || (d >= 8'h41 && d <= 8'h46)) begin
			qwr.entry.is_hex  = 1'b1;
			qwr.entry.hex_val = d[3:0] + 4'd9;
		end
		qwr.entry.is_cr    = (d == hcbd_pkg::CH_CR);
		qwr.entry.is_lf    = (d == hcbd_pkg::CH_LF);
		qwr.entry.is_blank = (d == hcbd_pkg::CH_SP) || (d == hcbd_pkg::CH_TAB);
		qwr.entry.is_semi  = (d == hcbd_pkg::CH_SEMI);
		qwr.entry.last     = raw.last_byte;
	end

endmodule

>>> src/hcbd_queue.sv
// ----------------------------------------------------------------------------
// hcbd_queue
// Short queue of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module hcbd_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hcbd_pkg::queue_wr_t     qwr,
	input  logic                    pop,
	output hcbd_pkg::queue_status_t qstat,
	output hcbd_pkg::byte_cls_t     head
);

	hcbd_pkg::byte_cls_t               mem_q [hcbd_pkg::QUEUE_DEPTH];
	logic [hcbd_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [hcbd_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [hcbd_pkg::QUEUE_AW:0]       count_q;
	logic                              do_pop;

	assign qstat.full  = (count_q == (hcbd_pkg::QUEUE_AW+1)'(hcbd_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = mem_q[rd_ptr_q];
	assign do_pop      = pop && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qwr.push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (qwr.push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!qwr.push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (qwr.push)
			mem_q[wr_ptr_q] <= qwr.entry;
	end

endmodule

>>> src/hcbd_back.sv
// ----------------------------------------------------------------------------
// hcbd_back
// Response parser and chunk decoder with the result output register.
// ----------------------------------------------------------------------------
module hcbd_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hcbd_pkg::queue_status_t qstat,
	input  hcbd_pkg::byte_cls_t     head,
	output logic                    pop,
	hcbd_out_if.source              body
);

	hcbd_pkg::phase_t      phase_q, phase_d;
	logic [2:0]            prefix_idx_q, prefix_idx_d;
	logic [1:0]            line_end_q, line_end_d;
	logic [4:0]            pattern_idx_q, pattern_idx_d;
	logic [4:0]            pidx;
	logic                  chunked_q, chunked_d;
	hcbd_pkg::chunk_size_t remain_q, remain_d;
	logic [2:0]            flags_q, flags_d;
	logic                  settled_q, settled_d;

	logic                  out_valid_q;
	logic                  pv_q, fin_q, ok_q;
	logic [7:0]            pb_q;
	logic                  pv, fin, ok;

	assign pop = !qstat.empty && (!out_valid_q || body.ready);

	assign body.valid         = out_valid_q;
	assign body.payload_valid = pv_q;
	assign body.payload_byte  = pb_q;
	assign body.finished      = fin_q;
	assign body.success       = ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= hcbd_pkg::PH_PREFIX;
			prefix_idx_q  <= '0;
			line_end_q    <= hcbd_pkg::LE_NONE;
			pattern_idx_q <= '0;
			chunked_q     <= 1'b0;
			remain_q      <= '0;
			flags_q       <= '0;
			settled_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				phase_q       <= phase_d;
				prefix_idx_q  <= prefix_idx_d;
				line_end_q    <= line_end_d;
				pattern_idx_q <= pattern_idx_d;
				chunked_q     <= chunked_d;
				remain_q      <= remain_d;
				flags_q       <= flags_d;
				settled_q     <= settled_d;
				out_valid_q   <= 1'b1;
			end else if (body.ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pv_q  <= pv;
			pb_q  <= pv ? head.data : 8'd0;
			fin_q <= fin;
			ok_q  <= fin && ok;
		end
	end

	always_comb begin
		phase_d       = phase_q;
		prefix_idx_d  = prefix_idx_q;
		line_end_d    = line_end_q;
		pattern_idx_d = pattern_idx_q;
		chunked_d     = chunked_q;
		remain_d      = remain_q;
		flags_d       = flags_q;
		settled_d     = settled_q;
		pv            = 1'b0;
		fin           = 1'b0;
		ok            = 1'b0;
		pidx          = (pattern_idx_q >= hcbd_pkg::PATTERN_LEN) ? 5'd0 : pattern_idx_q;

		if (!settled_q) begin
			unique case (phase_q)
				hcbd_pkg::PH_PREFIX: begin
					if (prefix_idx_q < hcbd_pkg::PREFIX_LEN &&
						head.data == hcbd_pkg::prefix_char(prefix_idx_q)) begin
						prefix_idx_d = prefix_idx_q + 3'd1;
						if (prefix_idx_d == hcbd_pkg::PREFIX_LEN)
							phase_d = hcbd_pkg::PH_HEADER;
					end else begin
						fin = 1'b1;
					end
				end
				hcbd_pkg::PH_HEADER: begin
					if (head.lower == hcbd_pkg::pattern_char(pidx)) begin
						if (pidx + 5'd1 == hcbd_pkg::PATTERN_LEN) begin
							chunked_d     = 1'b1;
							pattern_idx_d = '0;
						end else begin
							pattern_idx_d = pidx + 5'd1;
						end
					end else begin
						pattern_idx_d = (head.lower == hcbd_pkg::CH_LOW_T) ? 5'd1 : 5'd0;
					end
					priority if (head.is_cr) begin
						line_end_d = (line_end_q == hcbd_pkg::LE_CRLF) ?
							hcbd_pkg::LE_CRLFCR : hcbd_pkg::LE_CR;
					end else if (head.is_lf && line_end_q == hcbd_pkg::LE_CRLFCR) begin
						line_end_d = hcbd_pkg::LE_NONE;
						flags_d    = '0;
						remain_d   = '0;
						phase_d    = chunked_d ? hcbd_pkg::PH_SIZE : hcbd_pkg::PH_PLAIN;
					end else if (head.is_lf && line_end_q == hcbd_pkg::LE_CR) begin
						line_end_d = hcbd_pkg::LE_CRLF;
					end else begin
						line_end_d = hcbd_pkg::LE_NONE;
					end
				end
				hcbd_pkg::PH_PLAIN: begin
					pv = 1'b1;
				end
				hcbd_pkg::PH_SIZE: begin
					priority if ((flags_q & hcbd_pkg::FL_EXT) != '0) begin
						if (head.is_cr)
							phase_d = hcbd_pkg::PH_SIZE_LF;
					end else if (head.is_hex) begin
						if ((flags_q & hcbd_pkg::FL_TRAIL) != '0 ||
							remain_q[hcbd_pkg::CHUNK_SIZE_BITS-1 -: 4] != 4'd0) begin
							fin = 1'b1;
						end else begin
							remain_d = {remain_q[hcbd_pkg::CHUNK_SIZE_BITS-5:0], head.hex_val};
							flags_d  = flags_q | hcbd_pkg::FL_DIGIT;
						end
					end else if (head.is_blank) begin
						if ((flags_q & hcbd_pkg::FL_DIGIT) != '0)
							flags_d = flags_q | hcbd_pkg::FL_TRAIL;
					end else if (head.is_semi) begin
						if ((flags_q & hcbd_pkg::FL_DIGIT) != '0)
							flags_d = flags_q | hcbd_pkg::FL_EXT;
						else
							fin = 1'b1;
					end else if (head.is_cr) begin
						phase_d = hcbd_pkg::PH_SIZE_LF;
					end else begin
						fin = 1'b1;
					end
				end
				hcbd_pkg::PH_SIZE_LF: begin
					priority if (head.is_lf) begin
						if ((flags_q & hcbd_pkg::FL_DIGIT) == '0) begin
							fin = 1'b1;
						end else if (remain_q == '0) begin
							fin = 1'b1;
							ok  = 1'b1;
						end else begin
							phase_d = hcbd_pkg::PH_DATA;
						end
					end else if ((flags_q & hcbd_pkg::FL_EXT) != '0) begin
						if (!head.is_cr)
							phase_d = hcbd_pkg::PH_SIZE;
					end else begin
						fin = 1'b1;
					end
				end
				hcbd_pkg::PH_DATA: begin
					pv = 1'b1;
					if (remain_q != '0)
						remain_d = remain_q - 1'b1;
					if (remain_q == hcbd_pkg::chunk_size_t'(1) || remain_q == '0)
						phase_d = hcbd_pkg::PH_DATA_CR;
				end
				hcbd_pkg::PH_DATA_CR: begin
					if (head.is_cr)
						phase_d = hcbd_pkg::PH_DATA_LF;
					else
						fin = 1'b1;
				end
				hcbd_pkg::PH_DATA_LF: begin
					if (head.is_lf) begin
						phase_d  = hcbd_pkg::PH_SIZE;
						flags_d  = '0;
						remain_d = '0;
					end else begin
						fin = 1'b1;
					end
				end
				default: begin
					fin = 1'b1;
				end
			endcase

			if (!fin && head.last) begin
				fin = 1'b1;
				ok  = (phase_d == hcbd_pkg::PH_PLAIN);
			end
			if (fin)
				settled_d = 1'b1;
		end

		if (head.last) begin
			phase_d       = hcbd_pkg::PH_PREFIX;
			prefix_idx_d  = '0;
			line_end_d    = hcbd_pkg::LE_NONE;
			pattern_idx_d = '0;
			chunked_d     = 1'b0;
			remain_d      = '0;
			flags_d       = '0;
			settled_d     = 1'b0;
		end
	end

endmodule

>>> src/http_chunked_body_decoder_core.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// HTTP/1.1 response body decoder with chunked transfer decoding.
//
// The raw channel takes one response byte per word, with last_byte on the
// final byte of a response. The body channel returns exactly one word per
// raw word: a decoded body byte when payload_valid is set, and finished with
// success on the byte that settles the outcome of the response.
// Throughput is one byte per cycle while body.ready is high and the queue holds bytes.
// An accepted raw byte is registered in the classified byte queue, then in
// the result register, before it shows as body valid.
// A body stall holds the result register; the four-entry queue keeps taking
// raw words until it fills, then raw.ready drops.
// Reset clears the queue, the result valid flag and the parser state; the
// next byte is the first byte of a new response.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core (
	input logic        clk,
	input logic        arst_n,
	hcbd_in_if.sink    raw,
	hcbd_out_if.source body
);

	hcbd_pkg::queue_wr_t     qwr;
	hcbd_pkg::queue_status_t qstat;
	hcbd_pkg::byte_cls_t     head;
	logic                    pop;

	hcbd_front u_front (
		.raw   (raw),
		.qstat (qstat),
		.qwr   (qwr)
	);

	hcbd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qwr    (qwr),
		.pop    (pop),
		.qstat  (qstat),
		.head   (head)
	);

	hcbd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.body   (body)
	);

endmodule
